// ===== src/alle_pkg.sv =====
// ----------------------------------------------------------------------------
// alle_pkg: shared types for the array linked list engine
// Action and status codes, and the write enables of the node memories.
// ----------------------------------------------------------------------------
package alle_pkg;

	typedef enum logic [3:0] {
		ACT_TRAVERSE = 4'd0,
		ACT_COUNT    = 4'd1,
		ACT_SEARCH   = 4'd2,
		ACT_INS_HEAD = 4'd3,
		ACT_INS_TAIL = 4'd4,
		ACT_INS_POS  = 4'd5,
		ACT_DEL_HEAD = 4'd6,
		ACT_DEL_TAIL = 4'd7,
		ACT_DEL_SLOT = 4'd8,
		ACT_DEL_VAL  = 4'd9
	} action_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_NOT_FOUND = 3'd1,
		STS_EMPTY     = 3'd2,
		STS_BAD_POS   = 3'd3,
		STS_FULL      = 3'd4
	} status_t;

	// write enables; both memories share one write address
	typedef struct packed {
		logic val;
		logic lnk;
	} mem_we_t;

endpackage

// ===== src/alle_mem.sv =====
// ----------------------------------------------------------------------------
// alle_mem: node value and next link memories
// One read address for both memories, data registered, write data forwarded
// on a same-address read. Links read as slot+1 until first written.
// ----------------------------------------------------------------------------
module alle_mem import alle_pkg::*; #(
	parameter int NODE_SLOTS = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [$clog2(NODE_SLOTS)-1:0]         raddr,
	input  logic [$clog2(NODE_SLOTS)-1:0]         waddr,
	input  mem_we_t                               we,
	input  logic [VALUE_BITS-1:0]                 val_wdata,
	input  logic [$clog2(NODE_SLOTS+1)-1:0]       lnk_wdata,
	output logic [VALUE_BITS-1:0]                 rd_val,
	output logic [$clog2(NODE_SLOTS+1)-1:0]       rd_lnk
);

	localparam int LW = $clog2(NODE_SLOTS + 1);

	logic [VALUE_BITS-1:0] val_mem [NODE_SLOTS];
	logic [LW-1:0]         lnk_mem [NODE_SLOTS];
	logic [NODE_SLOTS-1:0] lnk_vld_q;
	logic [VALUE_BITS-1:0] rd_val_q;
	logic [LW-1:0]         rd_lnk_q;
	logic [LW-1:0]         lnk_init;

	// free chain at reset: slot i points to i+1
	assign lnk_init = LW'(raddr) + LW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lnk_vld_q <= '0;
		end else if (we.lnk) begin
			lnk_vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we.val) begin
			val_mem[waddr] <= val_wdata;
		end
		if (we.lnk) begin
			lnk_mem[waddr] <= lnk_wdata;
		end
		if (we.val && waddr == raddr) begin
			rd_val_q <= val_wdata;
		end else begin
			rd_val_q <= val_mem[raddr];
		end
		if (we.lnk && waddr == raddr) begin
			rd_lnk_q <= lnk_wdata;
		end else if (lnk_vld_q[raddr]) begin
			rd_lnk_q <= lnk_mem[raddr];
		end else begin
			rd_lnk_q <= lnk_init;
		end
	end

	assign rd_val = rd_val_q;
	assign rd_lnk = rd_lnk_q;

endmodule

// ===== src/alle_seq.sv =====
// ----------------------------------------------------------------------------
// alle_seq: list sequencer
// Holds head, free head and length; walks the list one node per cycle by
// feeding each read link back as the next read address; issues the link and
// value writes of inserts and deletes, and registers each result beat.
// ----------------------------------------------------------------------------
module alle_seq import alle_pkg::*; #(
	parameter int NODE_SLOTS = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [3:0]                            action,
	input  logic [31:0]                           item_value,
	input  logic [4:0]                            position,
	input  logic [3:0]                            node_slot,
	input  logic [4:0]                            prev_slot,
	output logic [$clog2(NODE_SLOTS)-1:0]         raddr,
	output logic [$clog2(NODE_SLOTS)-1:0]         waddr,
	output mem_we_t                               we,
	output logic [VALUE_BITS-1:0]                 val_wdata,
	output logic [$clog2(NODE_SLOTS+1)-1:0]       lnk_wdata,
	input  logic [VALUE_BITS-1:0]                 rd_val,
	input  logic [$clog2(NODE_SLOTS+1)-1:0]       rd_lnk,
	output logic                                  res_vld,
	output status_t                               res_status,
	output logic [$clog2(NODE_SLOTS+1)-1:0]       res_slot,
	output logic [VALUE_BITS-1:0]                 res_value,
	output logic [$clog2(NODE_SLOTS+1)-1:0]       res_count,
	output logic                                  res_last
);

	localparam int AW = $clog2(NODE_SLOTS);
	localparam int LW = $clog2(NODE_SLOTS + 1);
	localparam int CW = ((LW > 5) ? LW : 5) + 1;
	localparam logic [LW-1:0] END_MARK = LW'(NODE_SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_FREE,
		S_WALK,
		S_INS_FIX,
		S_UNL_FREE,
		S_UNL_PRED
	} state_t;

	state_t        state_q;
	action_t       act_q;
	logic [LW-1:0] head_q, free_q, len_q;
	logic [LW-1:0] p_q, pred_q, cnt_q, tgt_q, ins_q, hnext_q;
	logic [VALUE_BITS-1:0] v_q;
	logic [3:0]    nslot_q;
	logic [4:0]    praw_q;

	logic                  res_vld_q, res_last_q;
	status_t               res_status_q;
	logic [LW-1:0]         res_slot_q, res_count_q;
	logic [VALUE_BITS-1:0] res_value_q;

	action_t               act_in;
	logic [63:0]           v_ext;
	logic [VALUE_BITS-1:0] v_in;
	logic                  is_ins_in, pos_ok;
	logic [LW-1:0]         ins_tgt;
	logic                  lnk_end, val_match, slot_match, pred_ok, ins_at, is_ins_q;

	assign act_in    = action_t'(action);
	assign v_ext     = {{32{item_value[31]}}, item_value};
	assign v_in      = v_ext[VALUE_BITS-1:0];
	assign is_ins_in = (act_in == ACT_INS_HEAD) || (act_in == ACT_INS_TAIL) ||
	                   (act_in == ACT_INS_POS);
	assign pos_ok    = (position != 5'd0) &&
	                   (CW'(position) <= CW'(len_q) + CW'(1));

	// node number after which the new node goes; zero means new head
	always_comb begin
		case (act_in)
			ACT_INS_TAIL: ins_tgt = len_q;
			ACT_INS_POS:  ins_tgt = LW'(position - 5'd1);
			default:      ins_tgt = '0;
		endcase
	end

	// per-node tests on the node just read (p_q)
	assign lnk_end    = rd_lnk >= END_MARK;
	assign val_match  = rd_val == v_q;
	assign slot_match = CW'(p_q) == CW'(nslot_q);
	assign pred_ok    = (praw_q == 5'h1F) ? (pred_q == END_MARK) :
	                    (!praw_q[4] && pred_q != END_MARK && CW'(pred_q) == CW'(praw_q));
	assign ins_at     = cnt_q == tgt_q;
	assign is_ins_q   = (act_q == ACT_INS_HEAD) || (act_q == ACT_INS_TAIL) ||
	                    (act_q == ACT_INS_POS);

	// read address: walk follows the link just read
	always_comb begin
		unique case (state_q)
			S_IDLE:  raddr = is_ins_in ? AW'(free_q) : AW'(head_q);
			S_WALK:  raddr = AW'(rd_lnk);
			default: raddr = AW'(head_q);
		endcase
	end

	// memory writes
	always_comb begin
		we        = '0;
		waddr     = AW'(p_q);
		val_wdata = v_q;
		lnk_wdata = free_q;
		unique case (state_q)
			S_INS_FREE: begin
				we.val = 1'b1;
				waddr  = AW'(free_q);
				if (tgt_q == '0) begin
					we.lnk    = 1'b1;
					lnk_wdata = head_q;
				end
			end
			S_WALK: begin
				if (is_ins_q && ins_at) begin
					we.lnk    = 1'b1;
					lnk_wdata = ins_q;
				end
			end
			S_INS_FIX: begin
				we.lnk    = 1'b1;
				waddr     = AW'(ins_q);
				lnk_wdata = hnext_q;
			end
			S_UNL_FREE: begin
				we.lnk = 1'b1;
			end
			S_UNL_PRED: begin
				we.lnk    = 1'b1;
				waddr     = AW'(pred_q);
				lnk_wdata = hnext_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			act_q        <= ACT_TRAVERSE;
			head_q       <= END_MARK;
			free_q       <= '0;
			len_q        <= '0;
			p_q          <= '0;
			pred_q       <= '0;
			cnt_q        <= '0;
			tgt_q        <= '0;
			ins_q        <= '0;
			hnext_q      <= '0;
			v_q          <= '0;
			nslot_q      <= '0;
			praw_q       <= '0;
			res_vld_q    <= 1'b0;
			res_status_q <= STS_OK;
			res_slot_q   <= '0;
			res_value_q  <= '0;
			res_count_q  <= '0;
			res_last_q   <= 1'b0;
		end else begin
			res_vld_q   <= 1'b0;
			res_count_q <= '0;
			res_last_q  <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						act_q   <= act_in;
						v_q     <= v_in;
						nslot_q <= node_slot;
						praw_q  <= prev_slot;
						tgt_q   <= ins_tgt;
						p_q     <= head_q;
						pred_q  <= END_MARK;
						cnt_q   <= LW'(1);
						case (act_in) inside
							ACT_TRAVERSE, ACT_SEARCH, ACT_DEL_HEAD, ACT_DEL_TAIL,
							ACT_DEL_SLOT, ACT_DEL_VAL: begin
								if (head_q == END_MARK) begin
									res_vld_q    <= 1'b1;
									res_slot_q   <= END_MARK;
									res_status_q <= (act_in == ACT_SEARCH) ?
									                STS_NOT_FOUND : STS_EMPTY;
								end else begin
									state_q <= S_WALK;
								end
							end
							ACT_COUNT: begin
								res_vld_q    <= 1'b1;
								res_status_q <= STS_OK;
								res_slot_q   <= END_MARK;
								res_count_q  <= len_q;
							end
							ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
								if (free_q == END_MARK) begin
									res_vld_q    <= 1'b1;
									res_status_q <= STS_FULL;
									res_slot_q   <= END_MARK;
								end else if (act_in == ACT_INS_POS && !pos_ok) begin
									res_vld_q    <= 1'b1;
									res_status_q <= STS_BAD_POS;
									res_slot_q   <= END_MARK;
								end else begin
									state_q <= S_INS_FREE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_INS_FREE: begin
					free_q <= rd_lnk;
					ins_q  <= free_q;
					if (tgt_q == '0) begin
						head_q       <= free_q;
						len_q        <= len_q + LW'(1);
						res_vld_q    <= 1'b1;
						res_status_q <= STS_OK;
						res_slot_q   <= free_q;
						res_value_q  <= v_q;
						state_q      <= S_IDLE;
					end else begin
						p_q     <= head_q;
						pred_q  <= END_MARK;
						cnt_q   <= LW'(1);
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					case (act_q) inside
						ACT_TRAVERSE: begin
							res_vld_q    <= 1'b1;
							res_status_q <= STS_OK;
							res_slot_q   <= p_q;
							res_value_q  <= rd_val;
							res_last_q   <= lnk_end;
							p_q          <= rd_lnk;
							if (lnk_end) begin
								state_q <= S_IDLE;
							end
						end
						ACT_SEARCH: begin
							if (val_match || lnk_end) begin
								res_vld_q    <= 1'b1;
								res_status_q <= val_match ? STS_OK : STS_NOT_FOUND;
								res_slot_q   <= val_match ? p_q : END_MARK;
								res_value_q  <= rd_val;
								state_q      <= S_IDLE;
							end else begin
								p_q <= rd_lnk;
							end
						end
						ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
							// link into predecessor is written this cycle
							if (ins_at) begin
								hnext_q <= rd_lnk;
								state_q <= S_INS_FIX;
							end else begin
								p_q   <= rd_lnk;
								cnt_q <= cnt_q + LW'(1);
							end
						end
						default: begin
							// deletes: find the victim, then unlink it
							if ((act_q == ACT_DEL_HEAD) ||
							    (act_q == ACT_DEL_TAIL && lnk_end) ||
							    (act_q == ACT_DEL_VAL && val_match) ||
							    (act_q == ACT_DEL_SLOT && slot_match && pred_ok)) begin
								hnext_q     <= rd_lnk;
								res_value_q <= rd_val;
								state_q     <= S_UNL_FREE;
							end else if (act_q == ACT_DEL_SLOT && slot_match) begin
								res_vld_q    <= 1'b1;
								res_status_q <= STS_BAD_POS;
								res_slot_q   <= END_MARK;
								state_q      <= S_IDLE;
							end else if (lnk_end) begin
								res_vld_q    <= 1'b1;
								res_status_q <= STS_NOT_FOUND;
								res_slot_q   <= END_MARK;
								state_q      <= S_IDLE;
							end else begin
								pred_q <= p_q;
								p_q    <= rd_lnk;
							end
						end
					endcase
				end
				S_INS_FIX: begin
					len_q        <= len_q + LW'(1);
					res_vld_q    <= 1'b1;
					res_status_q <= STS_OK;
					res_slot_q   <= ins_q;
					res_value_q  <= v_q;
					state_q      <= S_IDLE;
				end
				S_UNL_FREE: begin
					free_q <= p_q;
					len_q  <= len_q - LW'(1);
					if (pred_q == END_MARK) begin
						head_q       <= hnext_q;
						res_vld_q    <= 1'b1;
						res_status_q <= STS_OK;
						res_slot_q   <= p_q;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_UNL_PRED;
					end
				end
				S_UNL_PRED: begin
					res_vld_q    <= 1'b1;
					res_status_q <= STS_OK;
					res_slot_q   <= p_q;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = state_q != S_IDLE;
	assign res_vld    = res_vld_q;
	assign res_status = res_status_q;
	assign res_slot   = res_slot_q;
	assign res_value  = res_value_q;
	assign res_count  = res_count_q;
	assign res_last   = res_last_q;

endmodule

// ===== src/array_linked_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// array_linked_list_engine_top: linked list in node memories with free list
// Ten list actions (traverse, count, search, three inserts, four deletes)
// on a singly linked list whose nodes live in a value and a link memory.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                | payload
//  ----------+--------------------------+------------------------------------
//  command   | start / busy, beat when  | action, item_value, position,
//            | start && !busy           | node_slot, prev_slot
//  result    | strobe, one cycle, beat  | status, found_slot, node_value,
//            | at the closing edge      | node_count, last_result
//
// The list is walked one node per cycle, the read link of each node
// being the next read address of the link memory. Count and error replies
// come straight from idle; traverse, search and deletes walk the list, and
// an unlink adds a free-list write and, off the head, a predecessor write;
// inserts take a free slot and, off the head, walk to the position and fix the links.
// Reset: list empty, free list chains every slot; link memory entries read
// as slot+1 until first written, so no clearing pass is needed.
// Results go out through a register and cannot be stalled; busy drops with
// the last beat, so the next command may be taken while that beat is shown.
// ----------------------------------------------------------------------------
module array_linked_list_engine_top import alle_pkg::*; #(
	parameter int NODE_SLOTS = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  action,
	input  logic [31:0] item_value,
	input  logic [4:0]  position,
	input  logic [3:0]  node_slot,
	input  logic [4:0]  prev_slot,
	output logic        strobe,
	output logic [2:0]  status,
	output logic [4:0]  found_slot,
	output logic [31:0] node_value,
	output logic [4:0]  node_count,
	output logic        last_result
);

	localparam int AW = $clog2(NODE_SLOTS);
	localparam int LW = $clog2(NODE_SLOTS + 1);
	localparam logic [LW-1:0] END_MARK = LW'(NODE_SLOTS);

	// memory side
	logic [AW-1:0]         raddr, waddr;
	mem_we_t               we;
	logic [VALUE_BITS-1:0] val_wdata, rd_val;
	logic [LW-1:0]         lnk_wdata, rd_lnk;

	// result register contents
	logic                  res_vld, res_last;
	status_t               res_status;
	logic [LW-1:0]         res_slot, res_count;
	logic [VALUE_BITS-1:0] res_value;

	logic                  slot_live;
	logic [63:0]           value_wide;

	alle_mem #(
		.NODE_SLOTS (NODE_SLOTS),
		.VALUE_BITS (VALUE_BITS)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.raddr     (raddr),
		.waddr     (waddr),
		.we        (we),
		.val_wdata (val_wdata),
		.lnk_wdata (lnk_wdata),
		.rd_val    (rd_val),
		.rd_lnk    (rd_lnk)
	);

	alle_seq #(
		.NODE_SLOTS (NODE_SLOTS),
		.VALUE_BITS (VALUE_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.item_value (item_value),
		.position   (position),
		.node_slot  (node_slot),
		.prev_slot  (prev_slot),
		.raddr      (raddr),
		.waddr      (waddr),
		.we         (we),
		.val_wdata  (val_wdata),
		.lnk_wdata  (lnk_wdata),
		.rd_val     (rd_val),
		.rd_lnk     (rd_lnk),
		.res_vld    (res_vld),
		.res_status (res_status),
		.res_slot   (res_slot),
		.res_value  (res_value),
		.res_count  (res_count),
		.res_last   (res_last)
	);

	// no node behind the beat: slot reads -1 and value 0
	assign slot_live  = res_slot < END_MARK;
	assign value_wide = 64'(res_value);

	assign strobe      = res_vld;
	assign status      = res_status;
	assign found_slot  = slot_live ? 5'(res_slot) : 5'h1F;
	assign node_value  = slot_live ? value_wide[31:0] : 32'd0;
	assign node_count  = 5'(res_count);
	assign last_result = res_last;

endmodule

// ===== tb/tb_array_linked_list_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_linked_list_engine_top: self-checking bench for the list engine
// Drives list commands through the start/busy port, keeps its own copy of the
// node memories, list head and free list, predicts every result beat, and
// checks each strobed beat field by field in order.
// ----------------------------------------------------------------------------
module tb_array_linked_list_engine_top;
	import alle_pkg::*;

	localparam int NODE_SLOTS = 16;
	localparam int LIST_END = NODE_SLOTS;     // link value that ends a list
	localparam logic [4:0] NO_SLOT = 5'h1F;   // -1: no node / predecessor is head
	localparam logic [3:0] ACT_SPARE_FIRST = 4'd10;   // codes the block ignores
	localparam logic [3:0] ACT_SPARE_LAST = 4'd15;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	// one command beat, plus how the driver should present it
	typedef struct {
		logic [3:0]  action;
		logic [31:0] value;
		logic [4:0]  pos;
		logic [3:0]  nslot;
		logic [4:0]  pslot;
		bit          steer;      // aim fields at the live list when presented
		bit          hold_for_drain;
		int          gap_pct;    // chance of an idle cycle per free slot
	} cmd_t;

	typedef struct {
		status_t     status;
		logic [4:0]  slot;
		logic [31:0] value;
		logic [4:0]  count;
		logic        last;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [3:0]  action = '0;
	logic [31:0] item_value = '0;
	logic [4:0]  position = '0;
	logic [3:0]  node_slot = '0;
	logic [4:0]  prev_slot = '0;
	logic        busy;
	logic        strobe;
	logic [2:0]  status;
	logic [4:0]  found_slot;
	logic [31:0] node_value;
	logic [4:0]  node_count;
	logic        last_result;

	// shadow of the engine: node memories, list head, free list head
	logic [31:0] node_vals [NODE_SLOTS];
	int          next_link [NODE_SLOTS];
	int          head_ptr;
	int          free_ptr;
	int          walk_q[$];          // slots of the list, head first

	cmd_t        pending_cmds[$];
	cmd_t        live_cmd;           // the command now on the port
	beat_t       expected_beats[$];

	int owed_beats = 0;              // beats predicted so far (driver side)
	int seen_beats = 0;              // beats strobed so far (monitor side)
	int items_taken = 0;
	int mismatch_count = 0;
	int peak_len = 0;
	int status_hits [5] = '{default: 0};

	mix_t block_plan [13] = '{MIX_FILL, MIX_FILL, MIX_EVEN, MIX_DRAIN, MIX_DRAIN,
		MIX_EVEN, MIX_FILL, MIX_FILL, MIX_EVEN, MIX_DRAIN, MIX_FILL, MIX_EVEN,
		MIX_DRAIN};

	array_linked_list_engine_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.item_value  (item_value),
		.position    (position),
		.node_slot   (node_slot),
		.prev_slot   (prev_slot),
		.strobe      (strobe),
		.status      (status),
		.found_slot  (found_slot),
		.node_value  (node_value),
		.node_count  (node_count),
		.last_result (last_result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Shadow list helpers
	// ------------------------------------------------------------------------

	// rebuild walk_q from head_ptr; capped at NODE_SLOTS entries
	function automatic void list_order();
		int p;
		walk_q.delete();
		p = head_ptr;
		while (p < LIST_END && walk_q.size() < NODE_SLOTS) begin
			walk_q.push_back(p);
			p = next_link[p];
		end
	endfunction

	// slot -1 (no node) forces the value field to zero
	function automatic void push_beat(status_t st, int slot, logic [31:0] val,
			logic [4:0] cnt, logic last);
		beat_t b;
		b.status = st;
		b.slot   = (slot < LIST_END) ? 5'(slot) : NO_SLOT;
		b.value  = (slot < LIST_END) ? val : '0;
		b.count  = cnt;
		b.last   = last;
		expected_beats.push_back(b);
	endfunction

	// apply one accepted command to the shadow list; returns beats owed
	function automatic int apply_list_action(cmd_t c);
		int len, target, s, p, pred, at;
		if (c.action > ACT_DEL_VAL)
			return 0;               // spare codes: no beat, no change
		list_order();
		len = walk_q.size();
		case (c.action) inside
			ACT_TRAVERSE: begin
				if (len == 0) begin
					push_beat(STS_EMPTY, LIST_END, '0, '0, 1'b1);
					return 1;
				end
				foreach (walk_q[i])
					push_beat(STS_OK, walk_q[i], node_vals[walk_q[i]], '0, i == len - 1);
				return len;
			end
			ACT_COUNT: begin
				push_beat(STS_OK, LIST_END, '0, 5'(len), 1'b1);
				return 1;
			end
			ACT_SEARCH: begin
				foreach (walk_q[i])
					if (node_vals[walk_q[i]] == c.value) begin
						push_beat(STS_OK, walk_q[i], c.value, '0, 1'b1);
						return 1;
					end
				push_beat(STS_NOT_FOUND, LIST_END, '0, '0, 1'b1);
				return 1;
			end
			ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
				// full wins over a bad position
				if (free_ptr >= LIST_END) begin
					push_beat(STS_FULL, LIST_END, '0, '0, 1'b1);
					return 1;
				end
				if (c.action == ACT_INS_HEAD)
					target = 1;
				else if (c.action == ACT_INS_TAIL)
					target = len + 1;
				else
					target = int'(c.pos);
				if (target < 1 || target > len + 1) begin
					push_beat(STS_BAD_POS, LIST_END, '0, '0, 1'b1);
					return 1;
				end
				s = free_ptr;
				free_ptr = next_link[s];
				node_vals[s] = c.value;
				if (target == 1) begin
					next_link[s] = head_ptr;
					head_ptr = s;
				end else begin
					p = walk_q[target - 2];
					next_link[s] = next_link[p];
					next_link[p] = s;
				end
				if (len + 1 > peak_len)
					peak_len = len + 1;
				push_beat(STS_OK, s, c.value, '0, 1'b1);
				return 1;
			end
			default: begin
				// the four deletes
				if (len == 0) begin
					push_beat(STS_EMPTY, LIST_END, '0, '0, 1'b1);
					return 1;
				end
				at = -1;
				case (c.action)
					ACT_DEL_HEAD: at = 0;
					ACT_DEL_TAIL: at = len - 1;
					default: begin
						foreach (walk_q[i])
							if (at < 0 && ((c.action == ACT_DEL_SLOT) ?
									walk_q[i] == int'(c.nslot) :
									node_vals[walk_q[i]] == c.value))
								at = i;
					end
				endcase
				if (at < 0) begin
					push_beat(STS_NOT_FOUND, LIST_END, '0, '0, 1'b1);
					return 1;
				end
				p = walk_q[at];
				pred = (at == 0) ? LIST_END : walk_q[at - 1];
				// delete by slot: prev_slot must name the real predecessor;
				// negative codes other than -1 never match
				if (c.action == ACT_DEL_SLOT && !((c.pslot == NO_SLOT) ?
						pred == LIST_END :
						(!c.pslot[4] && pred == int'(c.pslot)))) begin
					push_beat(STS_BAD_POS, LIST_END, '0, '0, 1'b1);
					return 1;
				end
				if (pred == LIST_END)
					head_ptr = next_link[p];
				else
					next_link[pred] = next_link[p];
				next_link[p] = free_ptr;
				free_ptr = p;
				push_beat(STS_OK, p, node_vals[p], '0, 1'b1);
				return 1;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------------

	task automatic push_cmd(logic [3:0] act, logic [31:0] val, logic [4:0] pos,
			logic [3:0] ns, logic [4:0] ps, bit steer, int gap, bit hold);
		cmd_t c;
		c.action = act;
		c.value = val;
		c.pos = pos;
		c.nslot = ns;
		c.pslot = ps;
		c.steer = steer;
		c.gap_pct = gap;
		c.hold_for_drain = hold;
		pending_cmds.push_back(c);
	endtask

	// a run of random commands leaning toward growth, shrinkage or neither;
	// spare action codes are mixed in but do not count toward the run
	task automatic add_block(mix_t mix, int count, int gap, bit hold);
		int made, r, kind;
		logic [3:0] act;
		logic [31:0] val;
		made = 0;
		while (made < count) begin
			r = $urandom_range(99, 0);
			case (mix)
				MIX_FILL:  kind = (r < 80) ? 0 : ((r < 90) ? 1 : 2);
				MIX_DRAIN: kind = (r < 15) ? 0 : ((r < 85) ? 1 : 2);
				default:   kind = (r < 35) ? 0 : ((r < 65) ? 1 : 2);
			endcase
			if ($urandom_range(99, 0) < 3)
				act = 4'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
			else if (kind == 0)
				act = 4'($urandom_range(ACT_INS_POS, ACT_INS_HEAD));
			else if (kind == 1)
				act = 4'($urandom_range(ACT_DEL_VAL, ACT_DEL_HEAD));
			else
				act = 4'($urandom_range(ACT_SEARCH, ACT_TRAVERSE));
			// small values collide often, so value hits also happen unsteered
			case ($urandom_range(3, 0))
				0: val = 32'($signed($urandom_range(7, 0)) - 4);
				1: val = ($urandom_range(1, 0) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				default: val = $urandom;
			endcase
			push_cmd(act, val, 5'($urandom_range(31, 0)), 4'($urandom), 5'($urandom),
				$urandom_range(3, 0) != 0, gap, hold && made == 0);
			if (act <= ACT_DEL_VAL)
				made++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: takes the beat on start && !busy, then offers the next command
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin : drive
			int added, pick;
			cmd_t nxt;
			added = 0;
			if (start && !busy) begin
				added = apply_list_action(live_cmd);
				items_taken++;
			end
			if (start && busy) begin
				// command still waiting; hold everything
			end else if (pending_cmds.size() != 0
					&& !(pending_cmds[0].hold_for_drain
						&& owed_beats + added != seen_beats)
					&& $urandom_range(99, 0) >= pending_cmds[0].gap_pct) begin
				nxt = pending_cmds.pop_front();
				// steered fields come from the shadow as it stands once every
				// earlier command is applied, so they hit real nodes
				if (nxt.steer) begin
					list_order();
					if (nxt.action == ACT_INS_POS)
						nxt.pos = 5'($urandom_range(walk_q.size() + 1, 1));
					if (walk_q.size() != 0) begin
						pick = $urandom_range(walk_q.size() - 1, 0);
						case (nxt.action) inside
							ACT_SEARCH, ACT_DEL_VAL: nxt.value = node_vals[walk_q[pick]];
							ACT_DEL_SLOT: begin
								nxt.nslot = 4'(walk_q[pick]);
								nxt.pslot = (pick == 0) ? NO_SLOT : 5'(walk_q[pick - 1]);
							end
							default: ;
						endcase
					end
				end
				live_cmd = nxt;
				start <= 1'b1;
				action <= nxt.action;
				item_value <= nxt.value;
				position <= nxt.pos;
				node_slot <= nxt.nslot;
				prev_slot <= nxt.pslot;
			end else begin
				start <= 1'b0;
			end
			owed_beats <= owed_beats + added;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: every strobed beat is taken and checked against the oldest
	// prediction; no back-pressure exists on this side
	// ------------------------------------------------------------------------
	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH @%0t: %s got %0h expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_beats <= 0;
		end else if (strobe) begin : check
			beat_t want;
			seen_beats <= seen_beats + 1;
			if (expected_beats.size() == 0) begin
				flag_mismatch("result beat with nothing expected", {27'd0, found_slot}, '0);
			end else begin
				want = expected_beats.pop_front();
				if (status !== want.status)
					flag_mismatch("status", 32'(status), 32'(want.status));
				if (found_slot !== want.slot)
					flag_mismatch("found_slot", 32'(found_slot), 32'(want.slot));
				if (node_value !== want.value)
					flag_mismatch("node_value", node_value, want.value);
				if (node_count !== want.count)
					flag_mismatch("node_count", 32'(node_count), 32'(want.count));
				if (last_result !== want.last)
					flag_mismatch("last_result", 32'(last_result), 32'(want.last));
				status_hits[want.status]++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequence: directed corner cases, then random runs in three idle phases
	// ------------------------------------------------------------------------
	initial begin
		for (int i = 0; i < NODE_SLOTS; i++) begin
			node_vals[i] = '0;
			next_link[i] = i + 1;
		end
		head_ptr = LIST_END;
		free_ptr = 0;

		// empty list: every read and every delete
		push_cmd(ACT_TRAVERSE, '0, '0, '0, '0, 0, 32, 0);
		push_cmd(ACT_COUNT, '0, '0, '0, '0, 0, 32, 0);
		push_cmd(ACT_SEARCH, '0, '0, '0, '0, 0, 32, 0);
		push_cmd(ACT_DEL_HEAD, '0, '0, '0, '0, 0, 32, 0);
		push_cmd(ACT_DEL_TAIL, '0, '0, '0, '0, 0, 32, 0);
		push_cmd(ACT_DEL_SLOT, '0, '0, 4'd0, NO_SLOT, 0, 32, 0);
		push_cmd(ACT_DEL_VAL, '0, '0, '0, '0, 0, 32, 0);
		// positions 0 and past the end are refused
		push_cmd(ACT_INS_POS, 32'd5, 5'd0, '0, '0, 0, 32, 0);
		push_cmd(ACT_INS_POS, 32'd5, 5'd2, '0, '0, 0, 32, 0);
		// build slots 0 -> 2 -> 1 -> 3 with extreme values
		push_cmd(ACT_INS_HEAD, 32'h7FFF_FFFF, '0, '0, '0, 0, 32, 0);
		push_cmd(ACT_INS_TAIL, 32'h8000_0000, '0, '0, '0, 0, 32, 0);
		push_cmd(ACT_INS_POS, 32'h0, 5'd2, '0, '0, 0, 32, 0);
		push_cmd(ACT_INS_POS, 32'hFFFF_FFFF, 5'd4, '0, '0, 0, 32, 0);
		push_cmd(ACT_INS_POS, 32'd9, 5'd31, '0, '0, 0, 32, 0);
		push_cmd(ACT_TRAVERSE, '0, '0, '0, '0, 0, 32, 0);
		push_cmd(ACT_COUNT, '0, '0, '0, '0, 0, 32, 0);
		push_cmd(ACT_SEARCH, 32'h0, '0, '0, '0, 0, 32, 0);
		push_cmd(ACT_SEARCH, 32'd12345, '0, '0, '0, 0, 32, 0);
		// slot deletes: wrong predecessor, slot not listed, middle, head
		push_cmd(ACT_DEL_SLOT, '0, '0, 4'd1, 5'd0, 0, 32, 0);
		push_cmd(ACT_DEL_SLOT, '0, '0, 4'd9, NO_SLOT, 0, 32, 0);
		push_cmd(ACT_DEL_SLOT, '0, '0, 4'd1, 5'd2, 0, 32, 0);
		push_cmd(ACT_DEL_SLOT, '0, '0, 4'd0, NO_SLOT, 0, 32, 0);
		push_cmd(ACT_DEL_VAL, 32'd5, '0, '0, '0, 0, 32, 0);
		push_cmd(ACT_DEL_VAL, 32'hFFFF_FFFF, '0, '0, '0, 0, 32, 0);
		push_cmd(ACT_SPARE_LAST, '0, '0, '0, '0, 0, 32, 0);
		push_cmd(ACT_DEL_TAIL, '0, '0, '0, '0, 0, 32, 0);

		// phases: sender idles 32%, then 81%, then not at all; each phase
		// starts by letting the block drain completely
		for (int b = 0; b < 13; b++)
			add_block(block_plan[b], 20, (b < 4) ? 32 : ((b < 9) ? 81 : 0),
				b == 0 || b == 4 || b == 9);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_cmds.size() == 0);
		@(negedge clk);
		while (start || owed_beats != seen_beats)
			@(negedge clk);
		// no stray beats may follow the last expected one
		repeat (40) @(negedge clk);

		if (expected_beats.size() != 0)
			flag_mismatch("beats never delivered", '0, expected_beats.size());
		$display("Run covered %0d commands and %0d result beats; list grew to %0d nodes",
			items_taken, seen_beats, peak_len);
		$display("Beats by status: ok %0d, not found %0d, empty %0d, bad pos %0d, full %0d",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog, many times the slowest legal run
	initial begin
		#400_000;
		$display("TIMEOUT after %0t", $time);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
